/* design/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and helpers for the bezier segment sampler.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int COORD_W     = 32;
    localparam int CNT_W       = 6;
    localparam int WEIGHT_W    = 16;
    localparam int MAX_SAMPLES = 63;

    localparam int DEN_W  = 48;
    localparam int NUM_W  = 24;
    localparam int QUOT_W = 32;
    localparam int STEP_W = 5;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 68;

    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_RQUAD = 2'd1;
    localparam logic [1:0] KIND_CUBIC = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic CFG_CURVE = 1'b0;
    localparam logic CFG_LINE  = 1'b1;

    localparam logic [STEP_W-1:0] T_DIV_STEPS     = 5'd24;
    localparam logic [STEP_W-1:0] RATIO_DIV_STEPS = 5'd31;

    typedef struct packed {
        logic [1:0]                segment_kind;
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic [WEIGHT_W-1:0]       weight_0;
        logic [WEIGHT_W-1:0]       weight_1;
        logic [WEIGHT_W-1:0]       weight_2;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic [CNT_W-1:0]          sample_index;
        logic                      last_sample;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem_init;
        logic              q_init;
        logic [NUM_W-1:0]  num;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    function automatic logic [COORD_W-1:0] sat_round(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            rnd = acc + (ACC_W'(1) <<< 29);
            r   = rnd >>> 30;
            hi  = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
            lo  = -hi - ACC_W'(1);
            if (r > hi)
            begin
                r = hi;
            end
            else if (r < lo)
            begin
                r = lo;
            end
            sat_round = r[COORD_W-1:0];
        end
    endfunction

endpackage

/* design/bezier_segment_sampler.sv */
// ----------------------------------------------------------------------------
// bezier_segment_sampler
// Uniform sampling of a line, rational quadratic or cubic bezier segment.
// ----------------------------------------------------------------------------
// One segment word in, N+1 sample words out (t = k/N, endpoints included, the
// last one flagged). The block handles one segment at a time and is not ready
// until the last sample has been taken. Every sample runs through a small
// sequencer that reuses one 35x18 multiplier and one bit-serial divider: the
// parameter t costs a 24-step division, each rational basis another 31-step
// division. Any output stall holds the current sample until it is taken.
module bezier_segment_sampler
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bss_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bss_pkg::out_word_t   out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [bss_pkg::CNT_W-1:0] cfg_data
);
    import bss_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TSTART = 4'd1;
    localparam logic [3:0] ST_TDIV   = 4'd2;
    localparam logic [3:0] ST_MULA   = 4'd3;
    localparam logic [3:0] ST_MULB   = 4'd4;
    localparam logic [3:0] ST_DEN    = 4'd5;
    localparam logic [3:0] ST_RINIT  = 4'd6;
    localparam logic [3:0] ST_RDIV   = 4'd7;
    localparam logic [3:0] ST_CMBA   = 4'd8;
    localparam logic [3:0] ST_CMBB   = 4'd9;
    localparam logic [3:0] ST_ROUND  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    localparam logic [3:0] OP_UU  = 4'd0;
    localparam logic [3:0] OP_UT  = 4'd1;
    localparam logic [3:0] OP_TT  = 4'd2;
    localparam logic [3:0] OP_A0  = 4'd3;
    localparam logic [3:0] OP_A1  = 4'd4;
    localparam logic [3:0] OP_A2  = 4'd5;
    localparam logic [3:0] OP_C0  = 4'd6;
    localparam logic [3:0] OP_C1  = 4'd7;
    localparam logic [3:0] OP_C2  = 4'd8;
    localparam logic [3:0] OP_C3  = 4'd9;

    localparam logic [16:0] ONE_T = 17'h10000;

    logic [3:0]         state_reg, state_next;
    logic [3:0]         op_reg, op_next;
    logic [1:0]         sel_reg, sel_next;
    logic               part_reg, part_next;
    logic               ax_reg, ax_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [1:0]         kind_reg, kind_next;
    logic [CNT_W-1:0]   curve_reg, curve_next;
    logic [CNT_W-1:0]   line_reg, line_next;

    logic signed [COORD_W-1:0] px_reg [4];
    logic signed [COORD_W-1:0] px_next [4];
    logic signed [COORD_W-1:0] py_reg [4];
    logic signed [COORD_W-1:0] py_next [4];
    logic [WEIGHT_W-1:0] w_reg [3];
    logic [WEIGHT_W-1:0] w_next [3];
    logic [DEN_W-1:0]    a_reg [3];
    logic [DEN_W-1:0]    a_next [3];
    logic [31:0]         c_reg [4];
    logic [31:0]         c_next [4];
    logic [16:0]         t_reg, t_next;
    logic [16:0]         u_reg, u_next;
    logic [32:0]         uu_reg, uu_next;
    logic [32:0]         ut_reg, ut_next;
    logic [32:0]         tt_reg, tt_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  y_reg, y_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W:0]           prod3;
    logic [PROD_W-1:0]         prod_r;
    logic [PROD_W:0]           prod3_r;
    div_cmd_t                  div_cmd;
    logic                      div_done;
    logic [QUOT_W-1:0]         quot;
    logic [CNT_W-1:0]          n_raw;
    logic [1:0]                last_sel;
    logic signed [COORD_W-1:0] pt;
    logic signed [ACC_W-1:0]   term;
    logic [DEN_W-1:0]          a_cur;
    logic [QUOT_W:0]           q_plus;

    bss_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    bss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .done  (div_done),
        .quot  (quot)
    );

    assign prod3   = {1'b0, prod} + {prod, 1'b0};
    assign prod_r  = prod + PROD_W'(1 << 17);
    assign prod3_r = prod3 + (PROD_W + 1)'(1 << 17);
    assign q_plus  = {1'b0, quot} + (QUOT_W + 1)'(1);
    assign a_cur   = a_reg[sel_reg];
    assign pt      = ax_reg ? py_reg[sel_reg] : px_reg[sel_reg];

    assign n_raw    = (in_data.segment_kind == KIND_LINE) ? line_reg : curve_reg;
    assign last_sel = (kind_reg == KIND_LINE) ? 2'd1 :
                      (kind_reg == KIND_RQUAD) ? 2'd2 : 2'd3;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CMBA)
        begin
            mul_a = {3'b0, c_reg[sel_reg]};
            mul_b = part_reg ? {2'b0, pt[15:0]} : {{2{pt[COORD_W-1]}}, pt[COORD_W-1:16]};
        end
        else
        begin
            case (op_reg)
                OP_UU:   begin mul_a = {18'b0, u_reg};     mul_b = {1'b0, u_reg}; end
                OP_UT:   begin mul_a = {18'b0, u_reg};     mul_b = {1'b0, t_reg}; end
                OP_TT:   begin mul_a = {18'b0, t_reg};     mul_b = {1'b0, t_reg}; end
                OP_A0:   begin mul_a = {2'b0, uu_reg};     mul_b = {2'b0, w_reg[0]}; end
                OP_A1:   begin mul_a = {1'b0, ut_reg, 1'b0}; mul_b = {2'b0, w_reg[1]}; end
                OP_A2:   begin mul_a = {2'b0, tt_reg};     mul_b = {2'b0, w_reg[2]}; end
                OP_C0:   begin mul_a = {2'b0, uu_reg};     mul_b = {1'b0, u_reg}; end
                OP_C1:   begin mul_a = {2'b0, uu_reg};     mul_b = {1'b0, t_reg}; end
                OP_C2:   begin mul_a = {2'b0, tt_reg};     mul_b = {1'b0, u_reg}; end
                OP_C3:   begin mul_a = {2'b0, tt_reg};     mul_b = {1'b0, t_reg}; end
                default: begin mul_a = '0;                 mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        div_cmd = '0;
        if (state_reg == ST_TSTART)
        begin
            div_cmd.start = 1'b1;
            div_cmd.den   = {{(DEN_W-CNT_W-1){1'b0}}, n_reg, 1'b0};
            div_cmd.num   = {1'b0, k_reg, 17'b0} + {{(NUM_W-CNT_W){1'b0}}, n_reg};
            div_cmd.steps = T_DIV_STEPS;
        end
        else if (state_reg == ST_RINIT)
        begin
            div_cmd.start    = 1'b1;
            div_cmd.den      = den_reg;
            div_cmd.q_init   = (a_cur >= den_reg);
            div_cmd.rem_init = div_cmd.q_init ? (a_cur - den_reg) : a_cur;
            div_cmd.steps    = RATIO_DIV_STEPS;
        end
    end

    assign term = part_reg ? ACC_W'(prod) : (ACC_W'(prod) <<< 16);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sel_next   = sel_reg;
        part_next  = part_reg;
        ax_next    = ax_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        kind_next  = kind_reg;
        curve_next = curve_reg;
        line_next  = line_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        uu_next    = uu_reg;
        ut_next    = ut_reg;
        tt_next    = tt_reg;
        den_next   = den_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_CURVE)
            begin
                curve_next = cfg_data;
            end
            else
            begin
                line_next = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_data.segment_kind;
                    n_next    = (n_raw == '0) ? CNT_W'(1) :
                                (n_raw > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : n_raw;
                    k_next    = '0;
                    px_next[0] = in_data.p0_x;
                    py_next[0] = in_data.p0_y;
                    px_next[1] = in_data.p1_x;
                    py_next[1] = in_data.p1_y;
                    px_next[2] = in_data.p2_x;
                    py_next[2] = in_data.p2_y;
                    px_next[3] = in_data.p3_x;
                    py_next[3] = in_data.p3_y;
                    w_next[0] = (in_data.weight_0 == '0) ? WEIGHT_W'(1) : in_data.weight_0;
                    w_next[1] = (in_data.weight_1 == '0) ? WEIGHT_W'(1) : in_data.weight_1;
                    w_next[2] = (in_data.weight_2 == '0) ? WEIGHT_W'(1) : in_data.weight_2;
                    state_next = ST_TSTART;
                end
            end
            ST_TSTART:
            begin
                state_next = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (div_done)
                begin
                    t_next   = quot[16:0];
                    u_next   = ONE_T - quot[16:0];
                    sel_next = '0;
                    op_next  = OP_UU;
                    if (kind_reg == KIND_LINE)
                    begin
                        c_next[0]  = {1'b0, u_next, 14'b0};
                        c_next[1]  = {1'b0, quot[16:0], 14'b0};
                        part_next  = 1'b0;
                        ax_next    = 1'b0;
                        acc_next   = '0;
                        state_next = ST_CMBA;
                    end
                    else
                    begin
                        state_next = ST_MULA;
                    end
                end
            end
            ST_MULA:
            begin
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                state_next = ST_MULA;
                op_next    = op_reg + 4'd1;
                case (op_reg)
                    OP_UU: uu_next = prod[32:0];
                    OP_UT: ut_next = prod[32:0];
                    OP_TT:
                    begin
                        tt_next = prod[32:0];
                        op_next = (kind_reg == KIND_RQUAD) ? OP_A0 : OP_C0;
                    end
                    OP_A0: a_next[0] = prod[DEN_W-1:0];
                    OP_A1: a_next[1] = prod[DEN_W-1:0];
                    OP_A2:
                    begin
                        a_next[2]  = prod[DEN_W-1:0];
                        state_next = ST_DEN;
                    end
                    OP_C0: c_next[0] = prod_r[49:18];
                    OP_C1: c_next[1] = prod3_r[49:18];
                    OP_C2: c_next[2] = prod3_r[49:18];
                    OP_C3:
                    begin
                        c_next[3]  = prod_r[49:18];
                        sel_next   = '0;
                        part_next  = 1'b0;
                        ax_next    = 1'b0;
                        acc_next   = '0;
                        state_next = ST_CMBA;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DEN:
            begin
                den_next   = a_reg[0] + a_reg[1] + a_reg[2];
                sel_next   = '0;
                state_next = ST_RINIT;
            end
            ST_RINIT:
            begin
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    c_next[sel_reg] = q_plus[QUOT_W:1];
                    if (sel_reg == 2'd2)
                    begin
                        sel_next   = '0;
                        part_next  = 1'b0;
                        ax_next    = 1'b0;
                        acc_next   = '0;
                        state_next = ST_CMBA;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = ST_RINIT;
                    end
                end
            end
            ST_CMBA:
            begin
                state_next = ST_CMBB;
            end
            ST_CMBB:
            begin
                acc_next   = acc_reg + term;
                part_next  = ~part_reg;
                state_next = ST_CMBA;
                if (part_reg)
                begin
                    if (sel_reg == last_sel)
                    begin
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            ST_ROUND:
            begin
                if (ax_reg)
                begin
                    y_next     = sat_round(acc_reg);
                    state_next = ST_OUT;
                end
                else
                begin
                    x_next     = sat_round(acc_reg);
                    ax_next    = 1'b1;
                    sel_next   = '0;
                    part_next  = 1'b0;
                    acc_next   = '0;
                    state_next = ST_CMBA;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (k_reg == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_TSTART;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_UU;
            sel_reg   <= '0;
            part_reg  <= 1'b0;
            ax_reg    <= 1'b0;
            k_reg     <= '0;
            n_reg     <= CNT_W'(1);
            kind_reg  <= KIND_LINE;
            curve_reg <= CNT_W'(8);
            line_reg  <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
            part_reg  <= part_next;
            ax_reg    <= ax_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            kind_reg  <= kind_next;
            curve_reg <= curve_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        w_reg   <= w_next;
        a_reg   <= a_next;
        c_reg   <= c_next;
        t_reg   <= t_next;
        u_reg   <= u_next;
        uu_reg  <= uu_next;
        ut_reg  <= ut_next;
        tt_reg  <= tt_next;
        den_reg <= den_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign in_ready              = (state_reg == ST_IDLE);
    assign out_valid             = (state_reg == ST_OUT);
    assign out_data.sample_x     = x_reg;
    assign out_data.sample_y     = y_reg;
    assign out_data.sample_index = k_reg;
    assign out_data.last_sample  = (k_reg == n_reg);

endmodule

/* design/bss_mul.sv */
// ----------------------------------------------------------------------------
// bss_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module bss_mul
(
    input  logic                                clk,
    input  logic signed [bss_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [bss_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [bss_pkg::PROD_W-1:0]   prod
);
    import bss_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* design/bss_div.sv */
// ----------------------------------------------------------------------------
// bss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bss_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bss_pkg::div_cmd_t               cmd,
    output logic                            done,
    output logic [bss_pkg::QUOT_W-1:0]      quot
);
    import bss_pkg::*;

    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [NUM_W-1:0]  num_reg,  num_next;
    logic [QUOT_W-1:0] q_reg,    q_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next = cmd.rem_init;
            den_next = cmd.den;
            num_next = cmd.num;
            q_next   = {{(QUOT_W-1){1'b0}}, cmd.q_init};
            cnt_next = cmd.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            q_next    = {q_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* design/bss_checker.sv */
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks for the bezier segment sampler.
// ----------------------------------------------------------------------------
module bss_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input bss_pkg::out_word_t   out_data
);
    import bss_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // no new segment while samples are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a sample is pending");

    // an accepted segment makes the block busy with no sample yet shown
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("segment accepted without going busy");

    // the last sample returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_sample |=> in_ready && !out_valid)
        else $error("block not idle after last sample");

    // a taken sample that is not the last drops out_valid while the next is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_sample |=> !out_valid)
        else $error("next sample shown without computing it");

endmodule

bind bezier_segment_sampler bss_checker u_bss_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
